[hdl/iirdf_pkg.sv]
// iirdf_pkg: widths, register indexes, payload and coefficient types of the
// direct form I filter. No dependencies; used by every file of the block.

package iirdf_pkg;

   // data widths
   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 24;
   localparam int HIST_W    = 24;
   localparam int HIST_FRAC = 8;
   localparam int COEF_FRAC = 20;
   localparam int ACC_W     = 52;

   // order range and default
   localparam int MAX_ORDER     = 3;
   localparam int ORDER_DEFAULT = 2;

   // configuration register map
   localparam int NUM_REGS  = 7;
   localparam int REG_IDX_W = 3;
   localparam logic [REG_IDX_W-1:0] REG_COEF_B0 = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_COEF_B1 = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_COEF_B2 = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_COEF_B3 = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_COEF_A1 = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_COEF_A2 = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_COEF_A3 = 3'd6;

   // reset value of b0 is 1.0 in Q4.20
   localparam logic [COEF_W-1:0] COEF_ONE = 24'h100000;

   // saturation limits of the output sample
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;

   typedef logic signed [COEF_W-1:0] coef_type;

   // b[k] is b_k, a[k] is a_(k+1)
   typedef struct packed {
      coef_type [MAX_ORDER:0]   b;
      coef_type [MAX_ORDER-1:0] a;
   } coef_set_type;

   // reset coefficient set: b0 = 1.0, every other tap zero
   localparam coef_set_type COEF_RESET =
      {{(MAX_ORDER*COEF_W){1'b0}}, COEF_ONE, {(MAX_ORDER*COEF_W){1'b0}}};

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       block_end;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] filtered;
      logic                       overflow;
      logic                       last_out;
   } rsp_type;

endpackage

[hdl/iirdf_csr.sv]
// iirdf_csr: coefficient register file written through the plain csr port.
// Depends on iirdf_pkg.

module iirdf_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wen,
   input  logic [iirdf_pkg::REG_IDX_W-1:0]  csr_index,
   input  logic [iirdf_pkg::COEF_W-1:0]     csr_wdata,
   output iirdf_pkg::coef_set_type          coefs
);

   iirdf_pkg::coef_set_type coef_ff;
   iirdf_pkg::coef_set_type coef_in;

   // decode of the write transaction, unknown indexes are dropped
   always_comb begin
      coef_in = coef_ff;
      if (csr_wen) begin
         case (csr_index)
            iirdf_pkg::REG_COEF_B0: coef_in.b[0] = csr_wdata;
            iirdf_pkg::REG_COEF_B1: coef_in.b[1] = csr_wdata;
            iirdf_pkg::REG_COEF_B2: coef_in.b[2] = csr_wdata;
            iirdf_pkg::REG_COEF_B3: coef_in.b[3] = csr_wdata;
            iirdf_pkg::REG_COEF_A1: coef_in.a[0] = csr_wdata;
            iirdf_pkg::REG_COEF_A2: coef_in.a[1] = csr_wdata;
            iirdf_pkg::REG_COEF_A3: coef_in.a[2] = csr_wdata;
            default:                coef_in = coef_ff;
         endcase
      end
   end

   // register bank, pass-through filter after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= iirdf_pkg::COEF_RESET;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coefs = coef_ff;

endmodule

[hdl/iirdf_datapath.sv]
// iirdf_datapath: multiply-accumulate, rounding and saturation for one sample.
// Purely combinational; depends on iirdf_pkg.

module iirdf_datapath #(
   parameter int ORDER = iirdf_pkg::ORDER_DEFAULT
) (
   input  iirdf_pkg::coef_set_type                   coefs,
   input  iirdf_pkg::req_type                        item,
   input  logic [ORDER-1:0][iirdf_pkg::SAMPLE_W-1:0] in_hist,
   input  logic [ORDER-1:0][iirdf_pkg::HIST_W-1:0]   out_hist,
   output iirdf_pkg::rsp_type                        result,
   output logic [iirdf_pkg::HIST_W-1:0]              new_hist
);

   localparam int ACC_W    = iirdf_pkg::ACC_W;
   localparam int SAMPLE_W = iirdf_pkg::SAMPLE_W;
   localparam int COEF_W   = iirdf_pkg::COEF_W;
   localparam int HIST_W   = iirdf_pkg::HIST_W;
   localparam int HFRAC    = iirdf_pkg::HIST_FRAC;
   localparam int CFRAC    = iirdf_pkg::COEF_FRAC;
   localparam int HFULL_W  = ACC_W - CFRAC;
   localparam int ORND_W   = HIST_W + 1;
   localparam int OFULL_W  = ORND_W - HFRAC;

   logic signed [ACC_W-1:0] ff_term [ORDER+1];
   logic signed [ACC_W-1:0] fb_term [ORDER];
   logic signed [ACC_W-1:0] acc;
   logic signed [ACC_W-1:0] acc_rnd;
   logic [HFULL_W-1:0]      h_full;
   logic [HFULL_W-HIST_W:0] h_top;
   logic                    h_ok;
   logic [HIST_W-1:0]       h_sat;
   logic [ORND_W-1:0]       o_rnd;
   logic [OFULL_W-1:0]      o_full;
   logic                    o_ok;

   // feedforward products, input scaled up to the Q.28 accumulator grid
   for (genvar k = 0; k <= ORDER; k++) begin : g_ff
      logic signed [SAMPLE_W-1:0]        x_k;
      logic signed [COEF_W+SAMPLE_W-1:0] prod;
      if (k == 0) begin : g_cur
         assign x_k = item.sample;
      end else begin : g_past
         assign x_k = $signed(in_hist[k-1]);
      end
      assign prod       = $signed(coefs.b[k]) * x_k;
      assign ff_term[k] = ACC_W'(prod) <<< HFRAC;
   end

   // feedback products on the Q16.8 output history
   for (genvar k = 0; k < ORDER; k++) begin : g_fb
      logic signed [COEF_W+HIST_W-1:0] prod;
      assign prod       = $signed(coefs.a[k]) * $signed(out_hist[k]);
      assign fb_term[k] = ACC_W'(prod);
   end

   // accumulate all taps
   always_comb begin
      acc = '0;
      for (int k = 0; k <= ORDER; k++) begin
         acc = acc + ff_term[k];
      end
      for (int k = 0; k < ORDER; k++) begin
         acc = acc - fb_term[k];
      end
   end

   // round half up to Q16.8, floor is the top slice
   assign acc_rnd = acc + (ACC_W'(1) <<< (CFRAC - 1));
   assign h_full  = acc_rnd[ACC_W-1:CFRAC];

   // saturate history value when the upper bits disagree with the sign
   assign h_top = h_full[HFULL_W-1:HIST_W-1];
   assign h_ok  = (h_top == '0) || (h_top == '1);
   assign h_sat = h_ok ? h_full[HIST_W-1:0]
                       : {h_full[HFULL_W-1], {(HIST_W-1){~h_full[HFULL_W-1]}}};

   // round history to an integer sample and saturate
   assign o_rnd  = {h_sat[HIST_W-1], h_sat} + ORND_W'(1 << (HFRAC - 1));
   assign o_full = o_rnd[ORND_W-1:HFRAC];
   assign o_ok   = (o_full[OFULL_W-1] == o_full[OFULL_W-2]);

   always_comb begin
      result.filtered = o_ok ? o_full[SAMPLE_W-1:0]
                             : {o_full[OFULL_W-1], {(SAMPLE_W-1){~o_full[OFULL_W-1]}}};
      result.overflow = ~h_ok | ~o_ok;
      result.last_out = item.block_end;
   end

   assign new_hist = h_sat;

endmodule

[hdl/iir_direct_form_filter_top.sv]
// iir_direct_form_filter_top: direct form I IIR filter, top level.
// Depends on iirdf_pkg, iirdf_csr and iirdf_datapath.
//
// Usage
//  - req channel: req_valid / req_stall / req_payload (sample, block_end).
//    A transaction completes at a clock edge with req_valid high and
//    req_stall low.
//  - rsp channel: rsp_valid / rsp_stall / rsp_payload (filtered, overflow,
//    last_out), one result per accepted sample, in order.
//  - csr port: csr_wen / csr_index / csr_wdata write the seven Q4.20
//    coefficients (b0..b3, a1..a3); write only while the filter is idle.
//  - path: an accepted sample waits in the input register, passes the
//    datapath and is held in the output register, from which rsp shows it.
//  - throughput: one sample per cycle unless rsp stalls. The rate is set
//    by the feedback loop: all products, the sum, rounding and saturation
//    are combinational from the input register to the output history register.
//  - reset: clears input and output history, drops any queued sample and
//    restores b0 = 1.0 with all other coefficients zero.
//  - stall: a stalled result holds in the output register; one more sample
//    waits in the input register, after which req_stall rises.

module iir_direct_form_filter_top #(
   parameter int ORDER = iirdf_pkg::ORDER_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  iirdf_pkg::req_type              req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output iirdf_pkg::rsp_type              rsp_payload,
   input  logic                            csr_wen,
   input  logic [iirdf_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [iirdf_pkg::COEF_W-1:0]    csr_wdata
);

   localparam int SAMPLE_W = iirdf_pkg::SAMPLE_W;
   localparam int HIST_W   = iirdf_pkg::HIST_W;

   iirdf_pkg::coef_set_type coefs;

   logic                    in_valid_ff, in_valid_in;
   iirdf_pkg::req_type      in_item_ff,  in_item_in;
   logic                    out_valid_ff, out_valid_in;
   iirdf_pkg::rsp_type      out_item_ff,  out_item_in;

   logic [ORDER-1:0][SAMPLE_W-1:0] in_hist_ff,  in_hist_in;
   logic [ORDER-1:0][HIST_W-1:0]   out_hist_ff, out_hist_in;

   iirdf_pkg::rsp_type      dp_result;
   logic [HIST_W-1:0]       dp_hist;

   logic out_free;
   logic advance;
   logic req_accept;

   // coefficient registers
   iirdf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coefs     (coefs)
   );

   // filter arithmetic
   iirdf_datapath #(
      .ORDER (ORDER)
   ) u_datapath (
      .coefs    (coefs),
      .item     (in_item_ff),
      .in_hist  (in_hist_ff),
      .out_hist (out_hist_ff),
      .result   (dp_result),
      .new_hist (dp_hist)
   );

   // handshake between the two register stages
   assign out_free   = ~out_valid_ff | ~rsp_stall;
   assign advance    = in_valid_ff & out_free;
   assign req_stall  = in_valid_ff & ~out_free;
   assign req_accept = req_valid & ~req_stall;

   // next values of pipeline and history
   always_comb begin
      in_valid_in  = req_accept | (in_valid_ff & ~advance);
      in_item_in   = req_accept ? req_payload : in_item_ff;
      out_valid_in = advance | (out_valid_ff & rsp_stall);
      out_item_in  = advance ? dp_result : out_item_ff;
      in_hist_in   = in_hist_ff;
      out_hist_in  = out_hist_ff;
      if (advance) begin
         for (int k = ORDER - 1; k > 0; k--) begin
            in_hist_in[k]  = in_hist_ff[k-1];
            out_hist_in[k] = out_hist_ff[k-1];
         end
         in_hist_in[0]  = in_item_ff.sample;
         out_hist_in[0] = dp_hist;
      end
   end

   // control and history registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         in_hist_ff   <= '0;
         out_hist_ff  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         in_hist_ff   <= in_hist_in;
         out_hist_ff  <= out_hist_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

endmodule

[hdl/iirdf_checker.sv]
// iirdf_checker: port-level assertions on the filter top, with its bind.
// Depends on iirdf_pkg and iir_direct_form_filter_top.

module iirdf_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input iirdf_pkg::rsp_type              rsp_payload
);

   // a held result keeps its value
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // reset empties the output register
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present right after reset");

   // input back-pressure only while a result is held
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output back-pressure");

   // a clipped result sits at one of the rails
   a_ovf_rail : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.overflow |->
         rsp_payload.filtered == iirdf_pkg::SAMPLE_MAX ||
         rsp_payload.filtered == iirdf_pkg::SAMPLE_MIN)
      else $error("overflow flagged off the saturation rails");

endmodule

bind iir_direct_form_filter_top iirdf_checker u_checker (.*);
